>>> rtl/rlsa_pkg.sv
// Shared types, codes and constants for the RGB LED saturating accumulator.
// No dependencies; every other file imports this package.
package rlsa_pkg;

  localparam int LED_COUNT_DEF = 64;
  localparam int CFG_IDX_W = 3;
  localparam logic [7:0] CH_MAX = 8'd255;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_ADD    = 2'd1,
    OP_RANGE  = 2'd2,
    OP_RENDER = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEYS_COUNT = 3'd0,
    REG_E_START    = 3'd1,
    REG_E_COUNT    = 3'd2,
    REG_TT_START   = 3'd3,
    REG_TT_COUNT   = 3'd4,
    REG_KEY_MAX    = 3'd5,
    REG_TT_MAX     = 3'd6
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_REN_RD,
    ST_REN_OUT
  } state_t;

  typedef struct packed {
    op_e        operation;
    logic [7:0] led_pos;
    logic [7:0] run_length;
    logic [7:0] add_red;
    logic [7:0] add_green;
    logic [7:0] add_blue;
  } in_item_t;

  typedef struct packed {
    logic [5:0] out_led;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       final_led;
  } out_item_t;

  typedef struct packed {
    logic [6:0] keys_led_count;
    logic [6:0] e_region_start;
    logic [6:0] e_region_count;
    logic [6:0] tt_region_start;
    logic [6:0] tt_region_count;
    logic [7:0] key_max_brightness;
    logic [7:0] tt_max_brightness;
  } cfg_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic clear;
    logic rd_en;
    logic wr_en;
    logic step;
    logic out_load;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic remain_zero;
    logic idx_last;
    logic out_free;
  } dp_status_t;

  function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[8] ? CH_MAX : s[7:0];
  endfunction

  function automatic logic [7:0] clamp_ch(input logic [7:0] v, input logic [7:0] lim);
    return (v < lim) ? v : lim;
  endfunction

endpackage

>>> rtl/rlsa_if.sv
// Handshake channel interfaces: command input, render output, config write.
// Depends on rlsa_pkg for the payload types.
interface rlsa_in_if import rlsa_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rlsa_out_if import rlsa_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rlsa_cfg_if import rlsa_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [7:0]           wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

>>> rtl/rlsa_cfg.sv
// Configuration register file: region bounds and brightness limits.
// Depends on rlsa_pkg.
module rlsa_cfg import rlsa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_valid,
  output logic                 wr_ready,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [7:0]           wr_data,
  output cfg_t                 cfg
);

  assign wr_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.keys_led_count     <= 7'd28;
      cfg.e_region_start     <= 7'd28;
      cfg.e_region_count     <= 7'd4;
      cfg.tt_region_start    <= 7'd32;
      cfg.tt_region_count    <= 7'd32;
      cfg.key_max_brightness <= CH_MAX;
      cfg.tt_max_brightness  <= CH_MAX;
    end else if (wr_valid) begin
      unique case (cfg_idx_e'(wr_index))
        REG_KEYS_COUNT: cfg.keys_led_count     <= wr_data[6:0];
        REG_E_START:    cfg.e_region_start     <= wr_data[6:0];
        REG_E_COUNT:    cfg.e_region_count     <= wr_data[6:0];
        REG_TT_START:   cfg.tt_region_start    <= wr_data[6:0];
        REG_TT_COUNT:   cfg.tt_region_count    <= wr_data[6:0];
        REG_KEY_MAX:    cfg.key_max_brightness <= wr_data;
        REG_TT_MAX:     cfg.tt_max_brightness  <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/rlsa_ctrl.sv
// Controller: sequences clear, add, range add and render over the datapath.
// Depends on rlsa_pkg.
module rlsa_ctrl import rlsa_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  op_e        in_op,
  output logic       in_ready,
  input  dp_status_t sts,
  output ctl_cmd_t   ctl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load = 1'b1;
          unique case (in_op)
            OP_CLEAR:  ctl.clear = 1'b1;
            OP_ADD:    state_next = ST_ADD_RD;
            OP_RANGE:  state_next = ST_ADD_RD;
            OP_RENDER: state_next = ST_REN_RD;
          endcase
        end
      end
      ST_ADD_RD: begin
        if (sts.remain_zero) begin
          state_next = ST_IDLE;
        end else begin
          ctl.rd_en  = 1'b1;
          state_next = ST_ADD_WR;
        end
      end
      ST_ADD_WR: begin
        ctl.wr_en  = 1'b1;
        ctl.step   = 1'b1;
        state_next = ST_ADD_RD;
      end
      ST_REN_RD: begin
        ctl.rd_en  = 1'b1;
        state_next = ST_REN_OUT;
      end
      ST_REN_OUT: begin
        // hold the read data until the output register frees up
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          ctl.step     = 1'b1;
          state_next   = sts.idx_last ? ST_IDLE : ST_REN_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

>>> rtl/rlsa_dp.sv
// Datapath: colour memory with per-entry valid bits, saturating adder,
// region clamp and the output register. Depends on rlsa_pkg.
module rlsa_dp import rlsa_pkg::*; #(
  parameter int LED_COUNT = LED_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  in_item_t   item,
  input  ctl_cmd_t   ctl,
  input  cfg_t       cfg,
  output dp_status_t sts,
  input  logic       out_ready,
  output logic       out_valid,
  output out_item_t  out_data
);

  localparam int AW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

  logic [23:0]          mem [LED_COUNT];
  logic [LED_COUNT-1:0] vbits;
  logic [23:0]          rdata;
  logic                 rvalid;
  logic [7:0]           idx;
  logic [7:0]           remain;
  logic [7:0]           add_r, add_g, add_b;
  logic [AW-1:0]        addr;
  logic                 in_range;
  logic [23:0]          cur;
  logic [23:0]          wdata;

  assign addr     = idx[AW-1:0];
  assign in_range = idx < 8'(LED_COUNT);
  assign cur      = rvalid ? rdata : 24'd0;
  assign wdata    = {sat_add(cur[23:16], add_r), sat_add(cur[15:8], add_g),
                     sat_add(cur[7:0], add_b)};

  assign sts.remain_zero = (remain == 8'd0);
  assign sts.idx_last    = (idx == 8'(LED_COUNT - 1));
  assign sts.out_free    = !out_valid || out_ready;

  // item registers and walk counters
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      add_r  <= item.add_red;
      add_g  <= item.add_green;
      add_b  <= item.add_blue;
      idx    <= (item.operation == OP_RENDER) ? 8'd0 : item.led_pos;
      remain <= (item.operation == OP_ADD) ? 8'd1 : item.run_length;
    end else if (ctl.step) begin
      idx    <= idx + 8'd1;
      remain <= remain - 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rdata  <= mem[addr];
      rvalid <= vbits[addr];
    end
    if (ctl.wr_en && in_range) begin
      mem[addr] <= wdata;
    end
  end

  // an entry without its valid bit reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vbits <= '0;
    end else if (ctl.clear) begin
      vbits <= '0;
    end else if (ctl.wr_en && in_range) begin
      vbits[addr] <= 1'b1;
    end
  end

  // region lookup and clamp for the LED being rendered
  logic [6:0] i7;
  logic       in_tt, in_e, in_keys, lit;
  logic [7:0] lim;
  out_item_t  beat;

  assign i7      = idx[6:0];
  assign in_tt   = (i7 >= cfg.tt_region_start) &&
                   ({1'b0, i7} < ({1'b0, cfg.tt_region_start} + {1'b0, cfg.tt_region_count}));
  assign in_e    = (i7 >= cfg.e_region_start) &&
                   ({1'b0, i7} < ({1'b0, cfg.e_region_start} + {1'b0, cfg.e_region_count}));
  assign in_keys = i7 < cfg.keys_led_count;
  assign lit     = in_tt || in_e || in_keys;
  assign lim     = in_tt ? cfg.tt_max_brightness : cfg.key_max_brightness;

  always_comb begin
    beat.out_led   = idx[5:0];
    beat.out_red   = lit ? clamp_ch(cur[23:16], lim) : 8'd0;
    beat.out_green = lit ? clamp_ch(cur[15:8], lim) : 8'd0;
    beat.out_blue  = lit ? clamp_ch(cur[7:0], lim) : 8'd0;
    beat.final_led = sts.idx_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_data <= beat;
    end
  end

endmodule

>>> rtl/rgb_led_saturating_accumulator.sv
// RGB LED saturating accumulator, top level.
// Clear takes effect when the command is accepted. Add, range add and render walk their LEDs
// one at a time, and a render LED also waits while the output register is stalled.
// Each LED costs one memory read, then the add write or the output load.
// Reset (synchronous) zeroes all entries at once via valid bits and restores register defaults.
// Depends on rlsa_pkg, rlsa_if, rlsa_cfg, rlsa_ctrl and rlsa_dp.
module rgb_led_saturating_accumulator import rlsa_pkg::*; #(
  parameter int LED_COUNT = LED_COUNT_DEF
) (
  input logic        clk,
  input logic        rst,
  rlsa_in_if.sink    cmd,
  rlsa_out_if.source result,
  rlsa_cfg_if.sink   cfg
);

  cfg_t       cfg_regs;
  ctl_cmd_t   ctl;
  dp_status_t sts;

  rlsa_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (cfg.valid),
    .wr_ready (cfg.ready),
    .wr_index (cfg.index),
    .wr_data  (cfg.wdata),
    .cfg      (cfg_regs)
  );

  rlsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd.valid),
    .in_op    (cmd.data.operation),
    .in_ready (cmd.ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  rlsa_dp #(.LED_COUNT(LED_COUNT)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .item      (cmd.data),
    .ctl       (ctl),
    .cfg       (cfg_regs),
    .sts       (sts),
    .out_ready (result.ready),
    .out_valid (result.valid),
    .out_data  (result.data)
  );

endmodule

>>> rtl/rlsa_check.sv
// Port-level checker for the accumulator, attached by bind.
// Depends on rlsa_pkg.
module rlsa_check import rlsa_pkg::*; #(
  parameter int LED_COUNT = LED_COUNT_DEF
) (
  input logic      clk,
  input logic      rst,
  input logic      cmd_valid,
  input logic      cmd_ready,
  input op_e       cmd_op,
  input logic      res_valid,
  input logic      res_ready,
  input out_item_t res_data
);

  // the last beat of a render carries the top index
  a_final_idx: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_data.final_led) |-> (res_data.out_led == 6'(LED_COUNT - 1)))
    else $error("final beat on wrong LED");

  // a render blocks further commands
  a_render_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready && cmd_op == OP_RENDER) |=> !cmd_ready)
    else $error("command taken during render");

  // a pending non-final beat means the render is still running
  a_mid_render: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_data.final_led) |-> !cmd_ready)
    else $error("command ready mid render");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(res_data)))
    else $error("stalled result beat changed");

endmodule

bind rgb_led_saturating_accumulator rlsa_check #(.LED_COUNT(LED_COUNT)) u_chk (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd.valid),
  .cmd_ready (cmd.ready),
  .cmd_op    (cmd.data.operation),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .res_data  (result.data)
);
